FILE: src/utv_pkg.sv
// ----------------------------------------------------------------------------
// utv_pkg
// Shared types, status codes and code point classes for the UTF-8 text
// validator.
// ----------------------------------------------------------------------------
package utv_pkg;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_TOO_LONG   = 3'd1,
    ST_BAD_UTF8   = 3'd2,
    ST_FORBIDDEN  = 3'd3,
    ST_TOO_MANY   = 3'd4,
    ST_TOO_SHORT  = 3'd5,
    ST_ONLY_SPACE = 3'd6,
    ST_EDGE_SPACE = 3'd7
  } status_e;

  typedef enum logic [1:0] {
    REG_MIN_SCALARS = 2'd0,
    REG_MAX_SCALARS = 2'd1,
    REG_MAX_BYTES   = 2'd2,
    REG_NOTES_MODE  = 2'd3
  } reg_index_e;

  localparam int unsigned CFG_WIDTH = 16;
  localparam int unsigned CP_WIDTH  = 21;

  localparam logic [CP_WIDTH-1:0] CP_MAX        = 21'h10FFFF;
  localparam logic [CP_WIDTH-1:0] CP_SURR_LO    = 21'h00D800;
  localparam logic [CP_WIDTH-1:0] CP_SURR_HI    = 21'h00DFFF;
  localparam logic [CP_WIDTH-1:0] CP_LINE_FEED  = 21'h00000A;
  localparam logic [CP_WIDTH-1:0] CP_LINE_SEP   = 21'h002028;
  localparam logic [CP_WIDTH-1:0] CP_PARA_SEP   = 21'h002029;
  localparam logic [CP_WIDTH-1:0] CP_MIN_TWO    = 21'h000080;
  localparam logic [CP_WIDTH-1:0] CP_MIN_THREE  = 21'h000800;
  localparam logic [CP_WIDTH-1:0] CP_MIN_FOUR   = 21'h010000;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  function automatic logic is_space(input logic [CP_WIDTH-1:0] v);
    return (v >= 21'h0009 && v <= 21'h000D) || v == 21'h0020 || v == 21'h0085 ||
           v == 21'h00A0 || v == 21'h1680 || (v >= 21'h2000 && v <= 21'h200A) ||
           v == 21'h2028 || v == 21'h2029 || v == 21'h202F || v == 21'h205F ||
           v == 21'h3000;
  endfunction

  function automatic logic is_control(input logic [CP_WIDTH-1:0] v);
    return v <= 21'h001F || (v >= 21'h007F && v <= 21'h009F);
  endfunction

endpackage

FILE: src/utf8_text_validator.sv
// ----------------------------------------------------------------------------
// utf8_text_validator
// Strict UTF-8 text checker with length limits and whitespace rules.
//
// A text enters one byte per request on the input channel (text_byte_i,
// no_byte_i, last_i with in_valid_i / in_stall_o). The request marked last
// produces one status request on the output channel (status_o with
// out_valid_o / out_stall_i). An empty text is a single request with
// no_byte_i and last_i set.
// Each byte is decoded combinationally; the status is registered and shows
// in the cycle after the last byte is taken. Throughput is one byte per cycle
// if unstalled, set by the single decode stage ahead of the state registers.
// The limit registers are written through the cfg channel, which is always
// ready; write them only while no text is in flight.
// Reset restores the default limits (min 1, max 64 scalars, max 256 bytes,
// notes mode off) and clears all text state and the output valid flag.
// While a status waits on a stalled receiver, the input is stalled too.
// ----------------------------------------------------------------------------
module utf8_text_validator
  import utv_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           text_byte_i,
  input  logic                 no_byte_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [CFG_WIDTH-1:0] cfg_data_i
);

  localparam int unsigned CW   = COUNT_BITS + 1;
  localparam int unsigned CMPW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;

  logic [CFG_WIDTH-1:0] min_scalars_q, max_scalars_q, max_bytes_q;
  logic                 notes_mode_q;

  logic [CW-1:0]       bytes_q, bytes_d, scal_q, scal_d;
  logic [1:0]          pend_q, pend_d;
  logic [2:0]          seqlen_q, seqlen_d;
  logic [CP_WIDTH-1:0] part_q, part_d;
  logic                first_sp_q, first_sp_d, last_sp_q, last_sp_d;
  logic                non_sp_q, non_sp_d, err_q, err_d;
  logic [2:0]          code_q, code_d;

  logic [CP_WIDTH-1:0] cp_val, part_new, cp_lowest;
  logic                cp_done, cp_sp;
  logic [2:0]          status_d, status_q;
  logic                out_valid_q, in_take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_take     = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_scalars_q <= CFG_WIDTH'(1);
      max_scalars_q <= CFG_WIDTH'(64);
      max_bytes_q   <= CFG_WIDTH'(256);
      notes_mode_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MIN_SCALARS: min_scalars_q <= cfg_data_i;
        REG_MAX_SCALARS: max_scalars_q <= cfg_data_i;
        REG_MAX_BYTES:   max_bytes_q   <= cfg_data_i;
        REG_NOTES_MODE:  notes_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    bytes_d    = bytes_q;
    scal_d     = scal_q;
    pend_d     = pend_q;
    seqlen_d   = seqlen_q;
    part_d     = part_q;
    first_sp_d = first_sp_q;
    last_sp_d  = last_sp_q;
    non_sp_d   = non_sp_q;
    err_d      = err_q;
    code_d     = code_q;
    cp_val     = {13'd0, text_byte_i};
    cp_done    = 1'b0;
    part_new   = {part_q[CP_WIDTH-7:0], text_byte_i[5:0]};
    case (seqlen_q)
      3'd2:    cp_lowest = CP_MIN_TWO;
      3'd3:    cp_lowest = CP_MIN_THREE;
      default: cp_lowest = CP_MIN_FOUR;
    endcase

    if (!no_byte_i) begin
      bytes_d = (&bytes_q) ? bytes_q : bytes_q + 1'b1;
      if (!err_q) begin
        if (pend_q == 2'd0) begin
          if (!text_byte_i[7]) begin
            cp_done = 1'b1;
          end else if (text_byte_i >= LEAD2_LO && text_byte_i <= LEAD2_HI) begin
            seqlen_d = 3'd2;
            part_d   = {16'd0, text_byte_i[4:0]};
            pend_d   = 2'd1;
          end else if (text_byte_i >= LEAD3_LO && text_byte_i <= LEAD3_HI) begin
            seqlen_d = 3'd3;
            part_d   = {17'd0, text_byte_i[3:0]};
            pend_d   = 2'd2;
          end else if (text_byte_i >= LEAD4_LO && text_byte_i <= LEAD4_HI) begin
            seqlen_d = 3'd4;
            part_d   = {18'd0, text_byte_i[2:0]};
            pend_d   = 2'd3;
          end else begin
            err_d  = 1'b1;
            code_d = ST_BAD_UTF8;
          end
        end else if (text_byte_i[7:6] != 2'b10) begin
          err_d    = 1'b1;
          code_d   = ST_BAD_UTF8;
          pend_d   = 2'd0;
          seqlen_d = 3'd0;
          part_d   = '0;
        end else if (pend_q == 2'd1) begin
          pend_d   = 2'd0;
          seqlen_d = 3'd0;
          part_d   = '0;
          cp_val   = part_new;
          if (part_new < cp_lowest || part_new > CP_MAX ||
              (part_new >= CP_SURR_LO && part_new <= CP_SURR_HI)) begin
            err_d  = 1'b1;
            code_d = ST_BAD_UTF8;
          end else begin
            cp_done = 1'b1;
          end
        end else begin
          pend_d = pend_q - 2'd1;
          part_d = part_new;
        end
      end
    end

    cp_sp = is_space(cp_val);
    if (cp_done) begin
      if (scal_q == '0) begin
        first_sp_d = cp_sp;
      end
      last_sp_d = cp_sp;
      if (!cp_sp) begin
        non_sp_d = 1'b1;
      end
      if ((is_control(cp_val) && (!notes_mode_q || cp_val != CP_LINE_FEED)) ||
          cp_val == CP_LINE_SEP || cp_val == CP_PARA_SEP) begin
        err_d  = 1'b1;
        code_d = ST_FORBIDDEN;
      end else begin
        scal_d = (&scal_q) ? scal_q : scal_q + 1'b1;
        if (CMPW'(scal_d) > CMPW'(max_scalars_q)) begin
          err_d  = 1'b1;
          code_d = ST_TOO_MANY;
        end
      end
    end

    if (CMPW'(bytes_d) > CMPW'(max_bytes_q)) begin
      status_d = ST_TOO_LONG;
    end else if (err_d) begin
      status_d = code_d;
    end else if (pend_d != 2'd0) begin
      status_d = ST_BAD_UTF8;
    end else if (CMPW'(scal_d) < CMPW'(min_scalars_q)) begin
      status_d = ST_TOO_SHORT;
    end else if (!notes_mode_q && !non_sp_d) begin
      status_d = ST_ONLY_SPACE;
    end else if (!notes_mode_q && (first_sp_d || last_sp_d)) begin
      status_d = ST_EDGE_SPACE;
    end else begin
      status_d = ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q    <= '0;
      scal_q     <= '0;
      pend_q     <= 2'd0;
      seqlen_q   <= 3'd0;
      part_q     <= '0;
      first_sp_q <= 1'b0;
      last_sp_q  <= 1'b0;
      non_sp_q   <= 1'b0;
      err_q      <= 1'b0;
      code_q     <= 3'd0;
    end else if (in_take) begin
      if (last_i) begin
        bytes_q    <= '0;
        scal_q     <= '0;
        pend_q     <= 2'd0;
        seqlen_q   <= 3'd0;
        part_q     <= '0;
        first_sp_q <= 1'b0;
        last_sp_q  <= 1'b0;
        non_sp_q   <= 1'b0;
        err_q      <= 1'b0;
        code_q     <= 3'd0;
      end else begin
        bytes_q    <= bytes_d;
        scal_q     <= scal_d;
        pend_q     <= pend_d;
        seqlen_q   <= seqlen_d;
        part_q     <= part_d;
        first_sp_q <= first_sp_d;
        last_sp_q  <= last_sp_d;
        non_sp_q   <= non_sp_d;
        err_q      <= err_d;
        code_q     <= code_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_take && last_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take && last_i) begin
      status_q <= status_d;
    end
  end

endmodule

FILE: tb/utf8_text_validator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_text_validator_test
// Self-checking bench for the UTF-8 text validator. A short table of texts
// covers empty text, bad lead bytes, overlong forms, surrogates, values above
// the code space, truncation, control code points and whitespace rules.
// Random texts follow under several limit settings, mostly well-formed with
// random content and some broken or noisy. Each status is checked against its
// pinned value or a bench-side decoder model, both sides idling and stalling.
// ----------------------------------------------------------------------------
module utf8_text_validator_test;
  import utv_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int PRESSURE_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 4;
  localparam int PHASE_ITEMS     = 66;
  localparam int PHASES          = 9;

  typedef struct packed {
    logic [7:0] b;
    logic       nb;
    logic       lst;
    logic       pinned;
    status_e    want;
  } dir_row_t;

  localparam dir_row_t DIRECTED_ROWS [26] = '{
    '{8'h00, 1'b1, 1'b1, 1'b1, ST_TOO_SHORT},
    '{8'h41, 1'b0, 1'b1, 1'b1, ST_OK},
    '{8'hFF, 1'b0, 1'b1, 1'b1, ST_BAD_UTF8},
    '{8'hC1, 1'b0, 1'b1, 1'b1, ST_BAD_UTF8},
    '{8'h20, 1'b0, 1'b1, 1'b1, ST_ONLY_SPACE},
    '{8'h00, 1'b0, 1'b1, 1'b1, ST_FORBIDDEN},
    '{8'hE2, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h80, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'hA8, 1'b0, 1'b1, 1'b1, ST_FORBIDDEN},
    '{8'hED, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'hA0, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h80, 1'b0, 1'b1, 1'b1, ST_BAD_UTF8},
    '{8'hF4, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h90, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h80, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h80, 1'b0, 1'b1, 1'b1, ST_BAD_UTF8},
    '{8'hE0, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h80, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h80, 1'b0, 1'b1, 1'b1, ST_BAD_UTF8},
    '{8'hE4, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'hB8, 1'b0, 1'b1, 1'b1, ST_BAD_UTF8},
    '{8'h5A, 1'b1, 1'b0, 1'b0, ST_OK},
    '{8'hF0, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h9F, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h98, 1'b0, 1'b0, 1'b0, ST_OK},
    '{8'h80, 1'b0, 1'b1, 1'b0, ST_OK}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [7:0]           text_byte = 8'h00;
  logic                 no_byte = 1'b0;
  logic                 is_last = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [2:0]           status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [1:0]           cfg_index = 2'd0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  logic [15:0] lim_min_scalars;
  logic [15:0] lim_max_scalars;
  logic [15:0] lim_max_bytes;
  logic        notes_on;
  logic [16:0] byte_count;
  logic [16:0] scalar_count;
  logic [1:0]  cont_left;
  logic [2:0]  seq_len;
  logic [20:0] cp_acc;
  logic        lead_space;
  logic        tail_space;
  logic        any_visible;
  logic        err_on;
  status_e     err_status;

  status_e    expected_status [$];
  status_e    due_status;
  logic [7:0] text_q [$];

  int send_idle_pct = 30;
  int recv_idle_pct = 58;
  int items_sent = 0;
  int results_seen = 0;
  int mismatch_count = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stuck_cycles = 0;

  utf8_text_validator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .text_byte_i (text_byte),
    .no_byte_i   (no_byte),
    .last_i      (is_last),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .status_o    (status),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic append_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic queue_status(input status_e s);
    expected_status.insert(expected_status.size(), s);
  endtask

  function automatic logic ws_point(input logic [20:0] v);
    return (v >= 21'h09 && v <= 21'h0D) || v == 21'h20 || v == 21'h85 || v == 21'hA0 ||
           v == 21'h1680 || (v >= 21'h2000 && v <= 21'h200A) || v == 21'h2028 ||
           v == 21'h2029 || v == 21'h202F || v == 21'h205F || v == 21'h3000;
  endfunction

  function automatic logic ctl_point(input logic [20:0] v);
    return v <= 21'h1F || (v >= 21'h7F && v <= 21'h9F);
  endfunction

  task automatic clear_text_state();
    byte_count   = '0;
    scalar_count = '0;
    cont_left    = '0;
    seq_len      = '0;
    cp_acc       = '0;
    lead_space   = 1'b0;
    tail_space   = 1'b0;
    any_visible  = 1'b0;
    err_on       = 1'b0;
    err_status   = ST_OK;
  endtask

  task automatic flag_error(input status_e code);
    if (!err_on) begin
      err_on     = 1'b1;
      err_status = code;
    end
    cont_left = '0;
    seq_len   = '0;
    cp_acc    = '0;
  endtask

  task automatic close_scalar(input logic [20:0] v);
    logic sp;
    sp = ws_point(v);
    if (scalar_count == '0) lead_space = sp;
    tail_space = sp;
    if (!sp) any_visible = 1'b1;
    if ((ctl_point(v) && !(notes_on && v == 21'h0A)) || v == 21'h2028 || v == 21'h2029) begin
      flag_error(ST_FORBIDDEN);
    end else begin
      if (scalar_count != '1) scalar_count++;
      if (scalar_count > {1'b0, lim_max_scalars}) flag_error(ST_TOO_MANY);
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b);
    logic [20:0] v;
    logic [20:0] lowest;
    if (byte_count != '1) byte_count++;
    if (!err_on) begin
      if (cont_left == 2'd0) begin
        if (b <= 8'h7F) begin
          close_scalar({13'd0, b});
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
          seq_len   = 3'd2;
          cp_acc    = {16'd0, b[4:0]};
          cont_left = 2'd1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
          seq_len   = 3'd3;
          cp_acc    = {17'd0, b[3:0]};
          cont_left = 2'd2;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
          seq_len   = 3'd4;
          cp_acc    = {18'd0, b[2:0]};
          cont_left = 2'd3;
        end else begin
          flag_error(ST_BAD_UTF8);
        end
      end else if (b[7:6] != 2'b10) begin
        flag_error(ST_BAD_UTF8);
      end else begin
        cp_acc = {cp_acc[14:0], b[5:0]};
        cont_left--;
        if (cont_left == 2'd0) begin
          v      = cp_acc;
          lowest = (seq_len == 3'd2) ? 21'h80 : (seq_len == 3'd3) ? 21'h800 : 21'h10000;
          seq_len = '0;
          cp_acc  = '0;
          if (v < lowest || v > 21'h10FFFF || (v >= 21'hD800 && v <= 21'hDFFF)) begin
            flag_error(ST_BAD_UTF8);
          end else begin
            close_scalar(v);
          end
        end
      end
    end
  endtask

  function automatic status_e text_status();
    if (byte_count > {1'b0, lim_max_bytes}) return ST_TOO_LONG;
    if (err_on) return err_status;
    if (cont_left != 2'd0) return ST_BAD_UTF8;
    if (scalar_count < {1'b0, lim_min_scalars}) return ST_TOO_SHORT;
    if (!notes_on && !any_visible) return ST_ONLY_SPACE;
    if (!notes_on && (lead_space || tail_space)) return ST_EDGE_SPACE;
    return ST_OK;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic nb, input logic lst,
                           input logic pinned, input status_e want);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid  <= 1'b0;
      text_byte <= 8'($urandom);
      no_byte   <= 1'($urandom_range(0, 1));
      is_last   <= 1'($urandom_range(0, 1));
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid  <= 1'b1;
    text_byte <= b;
    no_byte   <= nb;
    is_last   <= lst;
    do @(posedge clk); while (in_stall);
    if (!(nb && !lst)) items_sent++;
    if (!nb) absorb_byte(b);
    if (lst) begin
      if (pinned) queue_status(want);
      else queue_status(text_status());
      clear_text_state();
    end
  endtask

  task automatic write_reg(input reg_index_e idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_SCALARS: lim_min_scalars = value;
      REG_MAX_SCALARS: lim_max_scalars = value;
      REG_MAX_BYTES:   lim_max_bytes = value;
      REG_NOTES_MODE:  notes_on = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [15:0] mins, input logic [15:0] maxs,
                                input logic [15:0] maxb, input logic notes);
    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(REG_MIN_SCALARS, mins);
    write_reg(REG_MAX_SCALARS, maxs);
    write_reg(REG_MAX_BYTES, maxb);
    write_reg(REG_NOTES_MODE, {15'd0, notes});
    cfg_valid <= 1'b0;
  endtask

  function automatic int natural_len(input logic [20:0] v);
    if (v < 21'h80) return 1;
    if (v < 21'h800) return 2;
    if (v < 21'h10000) return 3;
    return 4;
  endfunction

  task automatic push_scalar(input logic [20:0] v, input int len);
    case (len)
      1: append_byte(v[7:0]);
      2: begin
        append_byte({3'b110, v[10:6]});
        append_byte({2'b10, v[5:0]});
      end
      3: begin
        append_byte({4'b1110, v[15:12]});
        append_byte({2'b10, v[11:6]});
        append_byte({2'b10, v[5:0]});
      end
      default: begin
        append_byte({5'b11110, v[20:18]});
        append_byte({2'b10, v[17:12]});
        append_byte({2'b10, v[11:6]});
        append_byte({2'b10, v[5:0]});
      end
    endcase
  endtask

  function automatic logic [20:0] pick_scalar();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 21'($urandom_range(21'h21, 21'h7E));
    if (r < 52) begin
      case ($urandom_range(0, 14))
        0: return 21'h09;
        1: return 21'h0A;
        2: return 21'h0B;
        3: return 21'h0C;
        4: return 21'h0D;
        5: return 21'h20;
        6: return 21'h85;
        7: return 21'hA0;
        8: return 21'h1680;
        9: return 21'($urandom_range(21'h2000, 21'h200A));
        10: return 21'h2028;
        11: return 21'h2029;
        12: return 21'h202F;
        13: return 21'h205F;
        default: return 21'h3000;
      endcase
    end
    if (r < 57) begin
      if ($urandom_range(0, 1) == 0) return 21'($urandom_range(21'h00, 21'h1F));
      return 21'($urandom_range(21'h7F, 21'h9F));
    end
    if (r < 70) return 21'($urandom_range(21'h80, 21'h7FF));
    if (r < 85) return 21'($urandom_range(21'h800, 21'hFFFF));
    return 21'($urandom_range(21'h10000, 21'h10FFFF));
  endfunction

  task automatic build_text();
    int kind;
    int n;
    int len;
    logic [20:0] v;
    text_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 88) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 10);
      if (kind >= 72 && n == 0) n = 1;
      repeat (n) begin
        v = pick_scalar();
        push_scalar(v, natural_len(v));
      end
      if (kind >= 72) begin
        case ($urandom_range(0, 4))
          0: text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom);
          1: void'(text_q.pop_back());
          2: begin
            len = $urandom_range(2, 4);
            v   = (len == 2) ? 21'($urandom_range(0, 21'h7F))
                : (len == 3) ? 21'($urandom_range(0, 21'h7FF))
                : 21'($urandom_range(0, 21'hFFFF));
            push_scalar(v, len);
          end
          3: push_scalar(21'($urandom_range(21'hD800, 21'hDFFF)), 3);
          default: push_scalar(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
        endcase
        repeat ($urandom_range(0, 3)) begin
          v = pick_scalar();
          push_scalar(v, natural_len(v));
        end
      end
    end else begin
      repeat ($urandom_range(0, 12)) append_byte(8'($urandom));
    end
  endtask

  task automatic send_text();
    int n;
    logic trailer;
    n = text_q.size();
    trailer = (n == 0) || ($urandom_range(0, 9) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b1, 1'b0, 1'b0, ST_OK);
      send_item(text_q[i], 1'b0, !trailer && (i == n - 1), 1'b0, ST_OK);
    end
    if (trailer) send_item(8'($urandom), 1'b1, 1'b1, 1'b0, ST_OK);
  endtask

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      results_seen++;
      if (expected_status.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected status %0d with none pending", status);
        mismatch_count++;
      end else begin
        due_status = expected_status.pop_front();
        if (status !== due_status) begin
          if (mismatch_count < 10) begin
            $display("status mismatch: expected %0d, got %0d", due_status, status);
          end
          mismatch_count++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= 60) begin
      hold_done = 1'b1;
      hold_left = PRESSURE_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [15:0] mins;
    logic [15:0] maxs;
    logic [15:0] maxb;
    logic        notes;
    int          phase_start;
    lim_min_scalars = 16'd1;
    lim_max_scalars = 16'd64;
    lim_max_bytes   = 16'd256;
    notes_on        = 1'b0;
    clear_text_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_ROWS[i]) begin
      send_item(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].nb, DIRECTED_ROWS[i].lst,
                DIRECTED_ROWS[i].pinned, DIRECTED_ROWS[i].want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin mins = 16'd0; maxs = 16'hFFFF; maxb = 16'hFFFF; notes = 1'b0; end
        2: begin mins = 16'd1; maxs = 16'd64; maxb = 16'd256; notes = 1'b0; end
        4: begin mins = 16'hFFFF; maxs = 16'd0; maxb = 16'd0; notes = 1'b1; end
        8: begin mins = 16'd0; maxs = 16'd0; maxb = 16'hFFFF; notes = 1'b1; end
        default: begin
          mins  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
          maxs  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(4, 40));
          maxb  = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(8, 96));
          notes = 1'($urandom_range(0, 1));
        end
      endcase
      apply_settings(mins, maxs, maxb, notes);
      send_idle_pct = (p < 3) ? 30 : (p < 6) ? 58 : 0;
      recv_idle_pct = (p < 3) ? 58 : (p < 6) ? 30 : 0;
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        build_text();
        send_text();
      end
    end

    in_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_status.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: utf8_text_validator.f
src/utv_pkg.sv
src/utf8_text_validator.sv
tb/utf8_text_validator_test.sv
